[rtl/fdr_pkg.sv]
// shared constants for the fresnel reflectance pipeline
package fdr_pkg;

   localparam int unsigned ONE_Q15     = 32768;
   // amplitude divider: numerator/denominator width and quotient width (q30, up to one)
   localparam int unsigned AMP_W       = 34;
   localparam int unsigned AMP_Q_W     = 31;
   localparam int unsigned AMP_STAGES  = AMP_Q_W;

endpackage

[rtl/fresnel_dielectric_reflectance.sv]
// top level: unpolarized dielectric fresnel reflectance, fully pipelined
//
// One item in, one item out. An item may enter every cycle while rsp is not stalled;
// its path runs through 4 stages of input select, squaring and the reflection test,
// 30 stages of a restoring divider for the transmitted sine squared (one quotient
// bit per stage), one stage to form one minus that, 16 stages of a digit-by-digit
// square root for the transmitted cosine, two stages of products and sums, 31
// stages of two parallel amplitude dividers, one squaring stage and the output
// register. The divider and square root chains set the latency. The whole pipeline
// advances together whenever the output register is empty or being taken, so a
// stall on rsp freezes every stage and nothing is lost or repeated. A negative or
// zero cosine swaps the indices and uses the magnitude. Total internal reflection
// (including a zero transmitted index) gives reflectance one with the flag set; a
// zero amplitude denominator gives reflectance one with the flag clear.
module fresnel_dielectric_reflectance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cos_incident[15:0], index_outside[31:16], index_inside[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // reflectance[15:0]
   output logic [0:0]  rsp_tuser    // total_reflection[0]
);

   localparam int unsigned DIV_N = 30;   // quotient bits of the sine divider
   localparam int unsigned SQ_N  = 16;   // root bits of the square root
   localparam int unsigned AW    = fdr_pkg::AMP_W;
   localparam int unsigned AQW   = fdr_pkg::AMP_Q_W;
   localparam int unsigned AD_N  = fdr_pkg::AMP_STAGES;

   // per item values carried down the pipe
   typedef struct packed {
      logic [16:0] ci;
      logic [15:0] ei;
      logic [15:0] et;
   } item_type;

   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: input select ----------------
   logic [15:0] raw;
   logic        entering;
   item_type    s1_in;
   logic        s1_v_ff;
   item_type    s1_it_ff;

   always_comb begin
      raw      = req_tdata[15:0];
      entering = (raw != 16'd0) && !raw[15];
      s1_in.ci = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      s1_in.ei = entering ? req_tdata[31:16] : req_tdata[47:32];
      s1_in.et = entering ? req_tdata[47:32] : req_tdata[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_it_ff <= s1_in;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic        s2_v_ff;
   item_type    s2_it_ff;
   logic [31:0] s2_eisq_ff, s2_etsq_ff;
   logic [30:0] s2_cisq_ff;
   logic [33:0] cisq_full;
   assign cisq_full = s1_it_ff.ci * s1_it_ff.ci;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_it_ff   <= s1_it_ff;
         s2_eisq_ff <= s1_it_ff.ei * s1_it_ff.ei;
         s2_etsq_ff <= s1_it_ff.et * s1_it_ff.et;
         s2_cisq_ff <= cisq_full[30:0];
      end
   end

   // ---------------- stage 3: ei^2 * sin_i^2 ----------------
   logic        s3_v_ff;
   item_type    s3_it_ff;
   logic [61:0] s3_a_ff;
   logic [31:0] s3_b_ff;
   logic [30:0] sin2;
   logic [62:0] a_full;
   assign sin2   = 31'h4000_0000 - s2_cisq_ff;
   assign a_full = s2_eisq_ff * sin2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_it_ff <= s2_it_ff;
         s3_a_ff  <= a_full[61:0];
         s3_b_ff  <= s2_etsq_ff;
      end
   end

   // ---------------- stage 4 + divider: sin_t^2 = A / et^2 ----------------
   // exact reflection test: A >= et^2 * 2^30; otherwise the quotient fits 30 bits
   logic        dv_v_ff   [0:DIV_N];
   item_type    dv_it_ff  [0:DIV_N];
   logic        dv_tir_ff [0:DIV_N];
   logic [31:0] dv_r_ff   [0:DIV_N];
   logic [31:0] dv_b_ff   [0:DIV_N];
   logic [29:0] dv_lo_ff  [0:DIV_N];
   logic [29:0] dv_q_ff   [0:DIV_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= s3_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_it_ff[0]  <= s3_it_ff;
         dv_tir_ff[0] <= s3_a_ff >= {s3_b_ff, 30'd0};
         dv_r_ff[0]   <= s3_a_ff[61:30];
         dv_b_ff[0]   <= s3_b_ff;
         dv_lo_ff[0]  <= s3_a_ff[29:0];
         dv_q_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [32:0] sh;
      logic        ge;
      logic [31:0] r_in;
      always_comb begin
         sh   = {dv_r_ff[k], dv_lo_ff[k][DIV_N-1-k]};
         ge   = sh >= {1'b0, dv_b_ff[k]};
         r_in = ge ? 32'(sh - {1'b0, dv_b_ff[k]}) : sh[31:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_it_ff[k+1]  <= dv_it_ff[k];
            dv_tir_ff[k+1] <= dv_tir_ff[k];
            dv_r_ff[k+1]   <= r_in;
            dv_b_ff[k+1]   <= dv_b_ff[k];
            dv_lo_ff[k+1]  <= dv_lo_ff[k];
            dv_q_ff[k+1]   <= {dv_q_ff[k][DIV_N-2:0], ge};
         end
      end
   end

   // ---------------- square root: ct = isqrt(2^30 - sin_t^2) ----------------
   logic        sr_v_ff    [0:SQ_N];
   item_type    sr_it_ff   [0:SQ_N];
   logic        sr_tir_ff  [0:SQ_N];
   logic [31:0] sr_rad_ff  [0:SQ_N];
   logic [17:0] sr_rem_ff  [0:SQ_N];
   logic [15:0] sr_root_ff [0:SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sr_v_ff[0] <= dv_v_ff[DIV_N];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sr_it_ff[0]   <= dv_it_ff[DIV_N];
         sr_tir_ff[0]  <= dv_tir_ff[DIV_N];
         sr_rad_ff[0]  <= 32'h4000_0000 - {2'b00, dv_q_ff[DIV_N]};
         sr_rem_ff[0]  <= '0;
         sr_root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      logic [19:0] sh;
      logic [19:0] trial;
      logic        ge;
      logic [17:0] rem_in;
      always_comb begin
         sh     = {sr_rem_ff[j], sr_rad_ff[j][31-2*j -: 2]};
         trial  = {2'b00, sr_root_ff[j], 2'b01};
         ge     = sh >= trial;
         rem_in = ge ? 18'(sh - trial) : sh[17:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sr_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sr_v_ff[j+1] <= sr_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sr_it_ff[j+1]   <= sr_it_ff[j];
            sr_tir_ff[j+1]  <= sr_tir_ff[j];
            sr_rad_ff[j+1]  <= sr_rad_ff[j];
            sr_rem_ff[j+1]  <= rem_in;
            sr_root_ff[j+1] <= {sr_root_ff[j][14:0], ge};
         end
      end
   end

   // ---------------- amplitude products ----------------
   logic        pm_v_ff, pm_tir_ff;
   logic [32:0] pm_ap_ff, pm_bp_ff, pm_as_ff, pm_bs_ff;
   item_type    sr_last;
   logic [15:0] ct;
   assign sr_last = sr_it_ff[SQ_N];
   assign ct      = sr_root_ff[SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_v_ff <= 1'b0;
      end else if (adv) begin
         pm_v_ff <= sr_v_ff[SQ_N];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pm_tir_ff <= sr_tir_ff[SQ_N];
         pm_ap_ff  <= sr_last.et * sr_last.ci;
         pm_bp_ff  <= 33'(sr_last.ei * ct);
         pm_as_ff  <= sr_last.ei * sr_last.ci;
         pm_bs_ff  <= 33'(sr_last.et * ct);
      end
   end

   // ---------------- numerators and denominators ----------------
   logic          nd_v_ff, nd_tir_ff, nd_bad_ff;
   logic [AW-1:0] nd_np_ff, nd_dp_ff, nd_ns_ff, nd_ds_ff;
   logic [AW-1:0] dp_in, ds_in;
   assign dp_in = {1'b0, pm_ap_ff} + {1'b0, pm_bp_ff};
   assign ds_in = {1'b0, pm_as_ff} + {1'b0, pm_bs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_v_ff <= 1'b0;
      end else if (adv) begin
         nd_v_ff <= pm_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         nd_tir_ff <= pm_tir_ff;
         nd_bad_ff <= (dp_in == '0) || (ds_in == '0);
         nd_dp_ff  <= dp_in;
         nd_ds_ff  <= ds_in;
         nd_np_ff  <= (pm_ap_ff >= pm_bp_ff) ? {1'b0, pm_ap_ff - pm_bp_ff}
                                             : {1'b0, pm_bp_ff - pm_ap_ff};
         nd_ns_ff  <= (pm_as_ff >= pm_bs_ff) ? {1'b0, pm_as_ff - pm_bs_ff}
                                             : {1'b0, pm_bs_ff - pm_as_ff};
      end
   end

   // ---------------- amplitude dividers, flags delayed alongside ----------------
   logic [AQW-1:0] r_par, r_perp;
   logic           ad_v_ff   [0:AD_N-1];
   logic           ad_tir_ff [0:AD_N-1];
   logic           ad_bad_ff [0:AD_N-1];

   fdr_amp_div u_div_par (
      .clock (clock),
      .en    (adv),
      .num   (nd_np_ff),
      .den   (nd_dp_ff),
      .quo   (r_par)
   );

   fdr_amp_div u_div_perp (
      .clock (clock),
      .en    (adv),
      .num   (nd_ns_ff),
      .den   (nd_ds_ff),
      .quo   (r_perp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AD_N; i++) begin
            ad_v_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         ad_v_ff[0] <= nd_v_ff;
         for (int i = 1; i < AD_N; i++) begin
            ad_v_ff[i] <= ad_v_ff[i-1];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ad_tir_ff[0] <= nd_tir_ff;
         ad_bad_ff[0] <= nd_bad_ff;
         for (int i = 1; i < AD_N; i++) begin
            ad_tir_ff[i] <= ad_tir_ff[i-1];
            ad_bad_ff[i] <= ad_bad_ff[i-1];
         end
      end
   end

   // ---------------- squared amplitudes ----------------
   logic        pw_v_ff, pw_tir_ff, pw_bad_ff;
   logic [61:0] pw_p_ff, pw_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_v_ff <= 1'b0;
      end else if (adv) begin
         pw_v_ff <= ad_v_ff[AD_N-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pw_tir_ff <= ad_tir_ff[AD_N-1];
         pw_bad_ff <= ad_bad_ff[AD_N-1];
         pw_p_ff   <= r_par * r_par;
         pw_s_ff   <= r_perp * r_perp;
      end
   end

   // ---------------- output register: mean, round, saturate ----------------
   logic [62:0] sum;
   logic [16:0] f_round;
   logic [15:0] refl_in;
   logic [15:0] rsp_refl_ff;
   logic        rsp_tir_ff;

   always_comb begin
      sum     = {1'b0, pw_p_ff} + {1'b0, pw_s_ff} + 63'(64'd1 << 45);
      f_round = sum[62:46];
      if (pw_tir_ff || pw_bad_ff || (f_round >= 17'(fdr_pkg::ONE_Q15))) begin
         refl_in = 16'(fdr_pkg::ONE_Q15);
      end else begin
         refl_in = f_round[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pw_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_refl_ff <= refl_in;
         rsp_tir_ff  <= pw_tir_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_refl_ff;
   assign rsp_tuser  = rsp_tir_ff;

endmodule

[rtl/fdr_amp_div.sv]
// pipelined restoring divider for amplitude ratios, floor(num * 2^30 / den), num <= den
module fdr_amp_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [fdr_pkg::AMP_W-1:0]     num,
   input  logic [fdr_pkg::AMP_W-1:0]     den,
   output logic [fdr_pkg::AMP_Q_W-1:0]   quo
);

   localparam int unsigned W  = fdr_pkg::AMP_W;
   localparam int unsigned QW = fdr_pkg::AMP_Q_W;
   localparam int unsigned NS = fdr_pkg::AMP_STAGES;

   logic [W-1:0]  r_ff [0:NS-1];
   logic [W-1:0]  d_ff [0:NS-1];
   logic [QW-1:0] q_ff [0:NS-1];

   // integer bit: num <= den, so the quotient of num / den is zero or one
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= den;
         if (num >= den) begin
            r_ff[0] <= num - den;
            q_ff[0] <= QW'(1);
         end else begin
            r_ff[0] <= num;
            q_ff[0] <= '0;
         end
      end
   end

   // one fraction bit per stage
   for (genvar k = 0; k < NS - 1; k++) begin : g_step
      logic [W:0]   sh;
      logic         ge;
      logic [W-1:0] r_in;
      always_comb begin
         sh   = {r_ff[k], 1'b0};
         ge   = sh >= {1'b0, d_ff[k]};
         r_in = ge ? W'(sh - {1'b0, d_ff[k]}) : sh[W-1:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1] <= r_in;
            d_ff[k+1] <= d_ff[k];
            q_ff[k+1] <= {q_ff[k][QW-2:0], ge};
         end
      end
   end

   assign quo = q_ff[NS-1];

endmodule
